/* hdl/mcs_pkg.sv */
// Shared types and constants for the markup comment-stripping line splitter.
package mcs_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_END  = 2'd2
  } mcs_kind_t;

  typedef struct packed {
    logic       in_string;
    logic       in_comment;
    logic [1:0] close_dashes;
    logic [1:0] open_match;
    logic       slash_pending;
    logic       line_comment;
    logic       escape_pending;
    logic       line_has_bytes;
  } mcs_state_t;

  typedef struct packed {
    mcs_kind_t  kind;
    logic [7:0] ch;
  } mcs_res_t;

  // results caused by one input beat, entry 0 first
  typedef struct packed {
    mcs_res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]       cnt;
  } mcs_list_t;

endpackage

/* hdl/mcs_step.sv */
// Per-byte scanner: next state and result list for one source byte.
module mcs_step (
  input  mcs_pkg::mcs_state_t state_i,
  input  logic [7:0]          ch_i,
  input  logic                eoi_i,
  output mcs_pkg::mcs_state_t state_o,
  output mcs_pkg::mcs_list_t  list_o
);
  import mcs_pkg::*;

  typedef struct packed {
    mcs_state_t st;
    mcs_list_t  lst;
  } work_t;

  function automatic work_t put(work_t w, mcs_kind_t k, logic [7:0] c);
    if (w.lst.cnt < CNT_W'(MAX_RES)) begin
      w.lst.ent[w.lst.cnt].kind = k;
      w.lst.ent[w.lst.cnt].ch   = (k == KIND_BYTE) ? c : 8'h00;
      w.lst.cnt = w.lst.cnt + CNT_W'(1);
    end
    return w;
  endfunction

  function automatic work_t emit(work_t w, logic [7:0] c);
    w = put(w, KIND_BYTE, c);
    w.st.line_has_bytes = 1'b1;
    return w;
  endfunction

  function automatic work_t end_line(work_t w);
    if (w.st.line_has_bytes) begin
      w = put(w, KIND_EOL, 8'h00);
      w.st.line_has_bytes = 1'b0;
      w.st.in_string = 1'b0;
    end
    return w;
  endfunction

  // held opener bytes go out as plain content
  function automatic work_t flush_open(work_t w);
    if (w.st.open_match >= 2'd1) w = emit(w, CH_LT);
    if (w.st.open_match >= 2'd2) w = emit(w, CH_BANG);
    if (w.st.open_match >= 2'd3) w = emit(w, CH_DASH);
    w.st.open_match = 2'd0;
    return w;
  endfunction

  function automatic work_t plain(work_t w, logic [7:0] c);
    unique case (c)
      CH_QUOTE: begin
        w.st.in_string = ~w.st.in_string;
        w = emit(w, c);
      end
      CH_SPACE, CH_TAB: begin
      end
      CH_NL: w = end_line(w);
      CH_SLASH: begin
        if (w.st.in_string) w = emit(w, c);
        else w.st.slash_pending = 1'b1;
      end
      CH_LT: begin
        if (w.st.in_string) w = emit(w, c);
        else w.st.open_match = 2'd1;
      end
      CH_BSLASH: begin
        w = emit(w, c);
        if (w.st.in_string) w.st.escape_pending = 1'b1;
      end
      default: w = emit(w, c);
    endcase
    return w;
  endfunction

  work_t      w;
  logic [7:0] want;

  always_comb begin
    w.st  = state_i;
    w.lst = '0;
    want  = (state_i.open_match == 2'd1) ? CH_BANG : CH_DASH;
    priority if (eoi_i) begin
      if (w.st.slash_pending) w = emit(w, CH_SLASH);
      w.st.slash_pending = 1'b0;
      w = flush_open(w);
      w = end_line(w);
      w = put(w, KIND_END, 8'h00);
      w.st = '0;
    end else if (w.st.in_comment) begin
      priority if (ch_i == CH_NL) begin
        w.st.close_dashes = 2'd0;
        w = end_line(w);
      end else if (ch_i == CH_DASH) begin
        // a third dash counts as a fresh first dash
        w.st.close_dashes = (w.st.close_dashes == 2'd1) ? 2'd2 : 2'd1;
      end else if (ch_i == CH_GT && w.st.close_dashes == 2'd2) begin
        w.st.in_comment   = 1'b0;
        w.st.close_dashes = 2'd0;
      end else begin
        w.st.close_dashes = 2'd0;
      end
    end else if (w.st.line_comment) begin
      if (ch_i == CH_NL) begin
        w.st.line_comment = 1'b0;
        w = end_line(w);
      end
    end else if (w.st.escape_pending) begin
      w.st.escape_pending = 1'b0;
      w = emit(w, ch_i);
    end else if (w.st.slash_pending) begin
      w.st.slash_pending = 1'b0;
      if (ch_i == CH_SLASH) begin
        w.st.line_comment = 1'b1;
      end else begin
        w = emit(w, CH_SLASH);
        w = emit(w, ch_i);
      end
    end else if (w.st.open_match != 2'd0) begin
      if (ch_i == want) begin
        if (w.st.open_match == 2'd3) begin
          // opener dashes already count toward the close
          w.st.open_match   = 2'd0;
          w.st.in_comment   = 1'b1;
          w.st.close_dashes = 2'd2;
        end else begin
          w.st.open_match = w.st.open_match + 2'd1;
        end
      end else begin
        w = flush_open(w);
        w = plain(w, ch_i);
      end
    end else begin
      w = plain(w, ch_i);
    end
  end

  assign state_o = w.st;
  assign list_o  = w.lst;

endmodule

/* hdl/mcs_drain.sv */
// Result register: holds one beat's result list and hands it out one entry per beat.
module mcs_drain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  mcs_pkg::mcs_list_t  list_i,
  output logic                can_load_o,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_ch,
  output logic                out_last
);
  import mcs_pkg::*;

  mcs_res_t [MAX_RES-1:0] ent_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   at_last;

  assign at_last    = (idx_r == CNT_W'(cnt_r - CNT_W'(1)));
  assign out_valid  = (cnt_r != '0);
  assign can_load_o = !out_valid || (out_ready && at_last);
  assign out_kind   = ent_r[idx_r].kind;
  assign out_ch     = ent_r[idx_r].ch;
  assign out_last   = at_last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load_i) begin
      cnt_nxt = list_i.cnt;
      idx_nxt = '0;
    end else if (out_valid && out_ready) begin
      if (at_last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) ent_r <= list_i.ent;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < cnt_r)
    else $error("result index past count");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_i && list_i.cnt != '0 |=> out_valid && idx_r == '0)
    else $error("loaded list not presented from first entry");

  a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> can_load_o)
    else $error("list loaded over undelivered results");

  a_keeps_going: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("list dropped before last entry");

endmodule

/* hdl/markup_comment_stripping_line_splitter_core.sv */
// Top level of the markup comment-stripping line splitter.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid/in_ready    in_ch[7:0], in_end_of_input
//   out_*        out  out_valid/out_ready  out_kind[1:0], out_ch[7:0], out_last
//
// One byte per cycle with out_ready high while each byte yields at most one
// result. A byte that yields n results (up to five, e.g. a flush at end of
// input) holds the result register for n beats; the input register keeps taking
// one more byte meanwhile. Bytes pass the input and result registers in turn.
// Reset clears the scanner state and both valid stages; no clearing pass.
// out_ready low stalls the result register, then the input register.
module markup_comment_stripping_line_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_ch,
  output logic       out_last
);
  import mcs_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_eoi_r;
  logic       s1_adv;
  logic       can_load;

  mcs_state_t state_r, state_nxt;
  mcs_list_t  list;

  assign s1_adv   = s1_valid_r && can_load;
  assign in_ready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_adv) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r  <= in_ch;
      s1_eoi_r <= in_end_of_input;
    end
  end

  mcs_step u_step (
    .state_i (state_r),
    .ch_i    (s1_ch_r),
    .eoi_i   (s1_eoi_r),
    .state_o (state_nxt),
    .list_o  (list)
  );

  mcs_drain u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (s1_adv),
    .list_i     (list),
    .can_load_o (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_ch     (out_ch),
    .out_last   (out_last)
  );

endmodule
